### sv/crb_pkg.sv
// shared types, command codes and helpers for the chunked ring buffer manager
// no dependencies
package crb_pkg;

  localparam int BW = 13;
  localparam int MAX_CHUNK_BYTES = 4096;

  typedef logic [BW-1:0] bytes_t;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_CHUNK_SIZE = 2'd0;
  localparam logic [1:0] REG_MIN_WRITE  = 2'd1;

  typedef struct packed {
    logic   full;
    bytes_t drained;
    bytes_t fill;
  } entry_t;

  typedef struct packed {
    logic   we;
    logic   inval;
    logic   inval_all;
    entry_t wdata;
  } mem_ctl_t;

  function automatic bytes_t room_f(logic ring_full, bytes_t fill, bytes_t sz);
    bytes_t r;
    if (ring_full) r = '0;
    else if (fill < sz) r = sz - fill;
    else r = '0;
    return r;
  endfunction

  function automatic bytes_t avail_f(entry_t e);
    bytes_t r;
    if (e.fill > e.drained) r = e.fill - e.drained;
    else r = '0;
    return r;
  endfunction

endpackage

### sv/crb_chunk_mem.sv
// per-chunk state memory: fill, drained count and full flag, two registered read ports
// entries carry valid bits so reset and clear take effect at once; uses crb_pkg
module crb_chunk_mem #(
  parameter int DEPTH = 9,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  crb_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output crb_pkg::entry_t   rdata_a,
  output crb_pkg::entry_t   rdata_b
);
  import crb_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.inval_all) begin
      valid <= '0;
    end else if (ctl.inval) begin
      valid[waddr] <= 1'b0;
    end else if (ctl.we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // an entry never written since clear reads as an empty chunk
  always_ff @(posedge clk) begin
    rdata_a <= valid[raddr_a] ? mem[raddr_a] : '0;
    rdata_b <= valid[raddr_b] ? mem[raddr_b] : '0;
  end

endmodule

### sv/crb_update.sv
// read-modify-write step for one command: clamps the amount, updates the chunk entry,
// the ring indices and the full count; uses crb_pkg
module crb_update #(
  parameter int NUM_CHUNKS = 8,
  parameter int IW         = 4
) (
  input  logic [1:0]         cmd,
  input  crb_pkg::bytes_t    amount,
  input  crb_pkg::bytes_t    sz,
  input  crb_pkg::bytes_t    min_write,
  input  logic [IW-1:0]      wi,
  input  logic [IW-1:0]      ri,
  input  logic [IW-1:0]      cnt,
  input  crb_pkg::entry_t    ent_a,
  input  crb_pkg::entry_t    ent_b,
  output crb_pkg::mem_ctl_t  ctl,
  output logic [IW-1:0]      waddr,
  output logic [IW-1:0]      wi_next,
  output logic [IW-1:0]      ri_next,
  output logic [IW-1:0]      cnt_next
);
  import crb_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(NUM_CHUNKS);
  localparam logic [IW-1:0] ONE  = IW'(1);

  logic [IW-1:0] nxt_w;
  logic [IW-1:0] nxt_r;
  logic          ring_full;
  bytes_t        room;
  bytes_t        amt_w;
  bytes_t        fill_w;
  bytes_t        thr;
  logic          wr_full;
  bytes_t        avail;
  bytes_t        amt_r;
  bytes_t        drn;
  logic          rd_done;

  assign nxt_w     = (wi == LAST) ? '0 : wi + ONE;
  assign nxt_r     = (ri == LAST) ? '0 : ri + ONE;
  assign ring_full = (nxt_w == ri);

  assign room    = room_f(ring_full, ent_a.fill, sz);
  assign amt_w   = (amount > room) ? room : amount;
  assign fill_w  = ent_a.fill + amt_w;
  assign thr     = (min_write >= sz) ? '0 : sz - min_write;
  // no room left also closes the chunk, so a zero minimum cannot stall the ring
  assign wr_full = (fill_w > thr) || (fill_w >= sz);

  assign avail   = avail_f(ent_b);
  assign amt_r   = (amount > avail) ? avail : amount;
  assign drn     = ent_b.drained + amt_r;
  assign rd_done = ent_b.full && (drn == ent_b.fill);

  always_comb begin
    ctl       = '0;
    ctl.wdata = ent_a;
    waddr     = wi;
    wi_next   = wi;
    ri_next   = ri;
    cnt_next  = cnt;
    unique case (cmd)
      CMD_WRITE: begin
        if (!ring_full) begin
          ctl.we         = 1'b1;
          ctl.wdata.fill = fill_w;
          if (wr_full) begin
            ctl.wdata.full = 1'b1;
            cnt_next       = cnt + ONE;
            wi_next        = nxt_w;
          end
        end
      end
      CMD_READ: begin
        waddr = ri;
        if (rd_done) begin
          // invalidating the entry empties the chunk
          ctl.inval = 1'b1;
          if (cnt != '0) cnt_next = cnt - ONE;
          ri_next = nxt_r;
        end else begin
          ctl.we            = 1'b1;
          ctl.wdata         = ent_b;
          ctl.wdata.drained = drn;
        end
      end
      CMD_CLEAR: begin
        ctl.inval_all = 1'b1;
        wi_next       = '0;
        ri_next       = '0;
        cnt_next      = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/chunked_ring_buffer_manager.sv
// chunked ring buffer manager: one command at a time; after the input transfer the block
// updates and writes back, re-reads the chunk entries, then loads the result register
// in_ready returns as the result register is loaded, so no new command is taken before
// the last is through; a stalled result holds the block in its last step. the chunk memory
// read is registered and must be done again after the write back
// reset (synchronous): indices and full count to 0, all chunk entries empty at once,
// chunk_size 4096, min_write_size 0
module chunked_ring_buffer_manager #(
  parameter int  NUM_CHUNKS = 8,
  localparam int IW         = $clog2(NUM_CHUNKS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  crb_pkg::bytes_t cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      command,
  input  crb_pkg::bytes_t amount,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [IW-1:0]   write_chunk,
  output crb_pkg::bytes_t write_offset,
  output crb_pkg::bytes_t write_space,
  output logic [IW-1:0]   read_chunk,
  output crb_pkg::bytes_t read_offset,
  output crb_pkg::bytes_t read_available,
  output logic [IW-1:0]   full_chunks
);
  import crb_pkg::*;

  localparam int            DEPTH = NUM_CHUNKS + 1;
  localparam logic [IW-1:0] LAST  = IW'(NUM_CHUNKS);
  localparam logic [IW-1:0] ONE   = IW'(1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SETTLE, S_DONE} state_t;

  state_t        state;
  logic [1:0]    cmd_q;
  bytes_t        amt_q;
  bytes_t        chunk_size;
  bytes_t        min_write_size;
  logic [IW-1:0] wi;
  logic [IW-1:0] ri;
  logic [IW-1:0] cnt;

  bytes_t        sz;
  mem_ctl_t      upd_ctl;
  mem_ctl_t      mem_ctl;
  logic [IW-1:0] waddr;
  logic [IW-1:0] wi_next;
  logic [IW-1:0] ri_next;
  logic [IW-1:0] cnt_next;
  entry_t        ent_a;
  entry_t        ent_b;
  logic          ring_full_now;
  logic [IW-1:0] nxt_w;

  assign sz = (32'(chunk_size) < MAX_CHUNK_BYTES) ? chunk_size : BW'(MAX_CHUNK_BYTES);

  crb_update #(
    .NUM_CHUNKS(NUM_CHUNKS),
    .IW        (IW)
  ) u_update (
    .cmd      (cmd_q),
    .amount   (amt_q),
    .sz       (sz),
    .min_write(min_write_size),
    .wi       (wi),
    .ri       (ri),
    .cnt      (cnt),
    .ent_a    (ent_a),
    .ent_b    (ent_b),
    .ctl      (upd_ctl),
    .waddr    (waddr),
    .wi_next  (wi_next),
    .ri_next  (ri_next),
    .cnt_next (cnt_next)
  );

  // memory writes only in the update step
  always_comb begin
    mem_ctl = upd_ctl;
    if (state != S_EXEC) mem_ctl = '0;
  end

  crb_chunk_mem #(
    .DEPTH(DEPTH),
    .AW   (IW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .waddr  (waddr),
    .raddr_a(wi),
    .raddr_b(ri),
    .rdata_a(ent_a),
    .rdata_b(ent_b)
  );

  assign nxt_w         = (wi == LAST) ? '0 : wi + ONE;
  assign ring_full_now = (nxt_w == ri);
  assign in_ready      = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size     <= BW'(4096);
      min_write_size <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_CHUNK_SIZE) chunk_size <= cfg_data;
      else if (cfg_index == REG_MIN_WRITE) min_write_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wi        <= '0;
      ri        <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // the result load in S_DONE takes over the valid flag
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= command;
            amt_q <= amount;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          wi    <= wi_next;
          ri    <= ri_next;
          cnt   <= cnt_next;
          state <= S_SETTLE;
        end
        S_SETTLE: begin
          // read data for the new indices lands at this edge
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            write_chunk    <= wi;
            write_offset   <= ent_a.fill;
            write_space    <= room_f(ring_full_now, ent_a.fill, sz);
            read_chunk     <= ri;
            read_offset    <= ent_b.drained;
            read_available <= avail_f(ent_b);
            full_chunks    <= cnt;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a command is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST)
    else $error("full chunk count exceeds ring capacity");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (wi <= LAST) && (ri <= LAST))
    else $error("ring index out of range");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result overwritten before transfer");

endmodule
